// ----- rtl/lgge_pkg.sv -----
// Shared types and constants for the life grid generation engine.
// No dependencies; imported by lgge_window and life_grid_generation_engine.
package lgge_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_STEP,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_STEP   = 2'd1,
        OP_READ   = 2'd2,
        OP_TOGGLE = 2'd3
    } t_opcode;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_COLOR_MAX   = 2'd2;

    localparam logic [3:0] NBR_SURVIVE = 4'd2;
    localparam logic [3:0] NBR_BIRTH   = 4'd3;

    // old alive bits of one column: row above, own row, row below
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_colvec;

    typedef struct packed {
        logic valid;
        logic first_col;
        logic cell_en;
    } t_win_ctl;

endpackage

// ----- rtl/lgge_window.sv -----
// 3x3 neighbourhood window over the column stream of a generation scan,
// with the B3/S23 rule and age update. Depends on lgge_pkg.
module lgge_window import lgge_pkg::*; #(
    parameter int AGE_BITS = 8
) (
    input  logic                i_clk,
    input  t_win_ctl            i_ctl,
    input  t_colvec             i_col,
    input  logic [AGE_BITS-1:0] i_old_age,
    input  logic [AGE_BITS-1:0] i_age_cap,
    output logic                o_alive,
    output logic [AGE_BITS-1:0] o_age
);

    t_colvec    r_w1;
    t_colvec    r_w2;
    t_colvec    w1e;
    t_colvec    w2e;
    logic [3:0] nbr_cnt;
    logic       self_alive;

    // columns left of the grid edge read as dead
    assign w1e = i_ctl.first_col ? '0 : r_w1;
    assign w2e = i_ctl.first_col ? '0 : r_w2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_w2 <= w1e;
            r_w1 <= i_col;
        end
    end

    assign self_alive = w1e.mid;
    assign nbr_cnt = 4'(w2e.top) + 4'(w2e.mid) + 4'(w2e.bot)
                   + 4'(w1e.top) + 4'(w1e.bot)
                   + 4'(i_col.top) + 4'(i_col.mid) + 4'(i_col.bot);

    always_comb begin
        priority if (self_alive && (nbr_cnt == NBR_SURVIVE || nbr_cnt == NBR_BIRTH)) begin
            o_alive = 1'b1;
            o_age   = (i_old_age < i_age_cap) ? i_old_age + AGE_BITS'(1) : i_old_age;
        end else if (!self_alive && nbr_cnt == NBR_BIRTH) begin
            o_alive = 1'b1;
            o_age   = AGE_BITS'(1);
        end else begin
            o_alive = 1'b0;
            o_age   = '0;
        end
    end

endmodule

// ----- rtl/life_grid_generation_engine.sv -----
// Life grid generation engine: cell memory, command sequencer, generation scan.
// Depends on lgge_pkg and lgge_window.
//
// Usage:
//   Command words enter on i_in_valid/o_in_ready (opcode, col, row, alive_in,
//   age_in). Write and toggle change one cell, read returns one result word
//   on o_out_valid/i_out_ready, step advances the grid by one generation.
//   Configuration words (grid_width, grid_height, color_max) enter on
//   i_cfg_valid/o_cfg_ready with a register index and are always taken.
// Throughput:
//   Step scans the used area plus one dead row and column through the single
//   cell memory write port, one position a cycle.
// Reset:
//   i_rst_n is synchronous, active low. After it a clearing pass writes every
//   one of the 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) memory words with
//   o_in_ready low; configuration words are still taken.
// Stalls:
//   A read result waits in the output register; further commands are taken
//   meanwhile. A second read holds until the output register is free.
module life_grid_generation_engine import lgge_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int AGE_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [5:0] i_col,
    input  logic [5:0] i_row,
    input  logic       i_alive_in,
    input  logic [7:0] i_age_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_alive_out,
    output logic [7:0] o_age_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    localparam int CW       = $clog2(MAX_COLS);
    localparam int RW       = $clog2(MAX_ROWS);
    localparam int AW       = CW + RW;
    localparam int DEPTH    = 2 ** AW;
    localparam int CCW      = $clog2(MAX_COLS + 1);
    localparam int RCW      = $clog2(MAX_ROWS + 1);
    localparam int MW       = AGE_BITS + 1;
    localparam int AGE_MASK = 2 ** AGE_BITS - 1;
    localparam int RST_COLS = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam int RST_ROWS = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int RST_CAP  = (AGE_MASK < 15) ? AGE_MASK : 15;

    t_state               r_state, n_state;
    logic [CCW-1:0]       r_used_cols, n_used_cols;
    logic [RCW-1:0]       r_used_rows, n_used_rows;
    logic [AGE_BITS-1:0]  r_age_cap, n_age_cap;
    logic [AW-1:0]        r_clr_cnt;
    t_opcode              r_cmd_op;
    logic [AW-1:0]        r_cmd_addr;
    logic                 r_cmd_inside;
    logic [RCW-1:0]       r_rr, n_rr;
    logic [CCW-1:0]       r_cc, n_cc;
    logic                 r_out_valid;
    logic                 r_out_alive;
    logic [7:0]           r_out_age;

    logic [MW-1:0]        r_mem [DEPTH];
    logic [MW-1:0]        r_rda;
    logic [MW-1:0]        r_rdb;
    logic [1:0]           r_lb [MAX_COLS];
    logic [1:0]           r_lbq;

    t_win_ctl             r_s1_ctl;
    t_colvec              r_s1_ok;
    logic [CW-1:0]        r_s1_lb_addr;
    logic                 r_s1_col_real;
    logic [AW-1:0]        r_s1_waddr;

    t_opcode              in_op;
    logic                 in_acc;
    logic                 in_inside;
    logic [AW-1:0]        in_addr;
    logic                 s0_col_real;
    logic                 s0_end;
    t_win_ctl             s0_ctl;
    t_colvec              s0_ok;
    logic [AW-1:0]        s0_addr_a;
    logic [AW-1:0]        s0_addr_b;
    t_colvec              s1_vec;
    logic                 win_alive;
    logic [AGE_BITS-1:0]  win_age;
    logic                 out_load;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [MW-1:0]        mem_wdata;
    logic                 mem_rea;
    logic [AW-1:0]        mem_raddr_a;
    logic                 mem_reb;
    logic                 lb_re;
    logic [6:0]           cfg_size;
    int                   cap_i;

    // configuration
    assign o_cfg_ready = 1'b1;
    assign cfg_size    = i_cfg_data[6:0];

    always_comb begin
        if (cfg_size == '0) begin
            n_used_cols = CCW'(1);
            n_used_rows = RCW'(1);
        end else begin
            n_used_cols = (int'(cfg_size) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cfg_size);
            n_used_rows = (int'(cfg_size) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(cfg_size);
        end
        cap_i     = (i_cfg_data == '0) ? 0 : int'(i_cfg_data) - 1;
        n_age_cap = (cap_i > AGE_MASK) ? AGE_BITS'(AGE_MASK) : AGE_BITS'(cap_i);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_cols <= CCW'(RST_COLS);
            r_used_rows <= RCW'(RST_ROWS);
            r_age_cap   <= AGE_BITS'(RST_CAP);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_used_cols <= n_used_cols;
                CFG_GRID_HEIGHT: r_used_rows <= n_used_rows;
                CFG_COLOR_MAX:   r_age_cap   <= n_age_cap;
                default: ;
            endcase
        end
    end

    // command decode
    assign in_op     = t_opcode'(i_opcode);
    assign in_acc    = i_in_valid && o_in_ready;
    assign in_inside = (int'(i_col) < int'(r_used_cols)) && (int'(i_row) < int'(r_used_rows));
    assign in_addr   = {RW'(i_row), CW'(i_col)};

    // generation scan, position stage
    assign s0_col_real     = r_cc < r_used_cols;
    assign s0_end          = (r_rr == r_used_rows) && (r_cc == r_used_cols);
    assign s0_ok.bot       = s0_col_real && (r_rr < r_used_rows);
    assign s0_ok.mid       = s0_col_real && (r_rr != '0);
    assign s0_ok.top       = s0_col_real && (r_rr > RCW'(1));
    assign s0_ctl.valid    = (r_state == ST_STEP);
    assign s0_ctl.first_col = (r_cc == '0);
    assign s0_ctl.cell_en  = (r_rr != '0) && (r_cc != '0);
    assign s0_addr_a       = {RW'(r_rr), CW'(r_cc)};
    assign s0_addr_b       = {RW'(r_rr - RCW'(1)), CW'(r_cc - CCW'(1))};

    always_comb begin
        n_rr = r_rr;
        n_cc = r_cc;
        if (in_acc && in_op == OP_STEP) begin
            n_rr = '0;
            n_cc = '0;
        end else if (r_state == ST_STEP) begin
            if (r_cc == r_used_cols) begin
                n_cc = '0;
                n_rr = r_rr + RCW'(1);
            end else begin
                n_cc = r_cc + CCW'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr_cnt) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        OP_STEP:   n_state = ST_STEP;
                        OP_READ:   n_state = ST_ACCESS;
                        OP_TOGGLE: n_state = ST_ACCESS;
                        OP_WRITE:  n_state = ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ACCESS: begin
                if (r_cmd_op != OP_READ || !r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            ST_STEP: begin
                if (s0_end) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready  = 1'b0;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_s1_waddr;
        mem_wdata   = {win_alive, win_age};
        mem_rea     = 1'b0;
        mem_raddr_a = s0_addr_a;
        mem_reb     = 1'b0;
        lb_re       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                mem_raddr_a = in_addr;
                if (i_in_valid) begin
                    mem_rea   = (in_op == OP_READ || in_op == OP_TOGGLE);
                    mem_we    = (in_op == OP_WRITE) && in_inside;
                    mem_waddr = in_addr;
                    mem_wdata = {i_alive_in, AGE_BITS'(i_age_in)};
                end
            end
            ST_ACCESS: begin
                if (r_cmd_op == OP_READ) begin
                    out_load = !r_out_valid || i_out_ready;
                end else begin
                    mem_we    = r_cmd_inside;
                    mem_waddr = r_cmd_addr;
                    mem_wdata = {~r_rda[AGE_BITS],
                                 (r_rda[AGE_BITS-1:0] == '0) ? AGE_BITS'(1) : AGE_BITS'(0)};
                end
            end
            ST_STEP: begin
                mem_rea = 1'b1;
                mem_reb = 1'b1;
                lb_re   = s0_col_real;
                mem_we  = r_s1_ctl.valid && r_s1_ctl.cell_en;
            end
            ST_DRAIN: begin
                mem_we = r_s1_ctl.valid && r_s1_ctl.cell_en;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_rr        <= '0;
            r_cc        <= '0;
            r_out_valid <= 1'b0;
            r_s1_ctl    <= '0;
        end else begin
            r_state  <= n_state;
            r_rr     <= n_rr;
            r_cc     <= n_cc;
            r_s1_ctl <= s0_ctl;
            if (r_state == ST_CLEAR) r_clr_cnt <= r_clr_cnt + AW'(1);
            if (out_load)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd_op     <= in_op;
            r_cmd_addr   <= in_addr;
            r_cmd_inside <= in_inside;
        end
        if (out_load) begin
            r_out_alive <= r_cmd_inside & r_rda[AGE_BITS];
            r_out_age   <= r_cmd_inside ? 8'(r_rda[AGE_BITS-1:0]) : 8'd0;
        end
        r_s1_ok       <= s0_ok;
        r_s1_lb_addr  <= CW'(r_cc);
        r_s1_col_real <= s0_col_real;
        r_s1_waddr    <= s0_addr_b;
    end

    // cell memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we)  r_mem[mem_waddr] <= mem_wdata;
        if (mem_rea) r_rda <= r_mem[mem_raddr_a];
        if (mem_reb) r_rdb <= r_mem[s0_addr_b];
    end

    // line buffer of old alive bits: {two rows up, one row up}
    assign s1_vec.top = r_lbq[1] & r_s1_ok.top;
    assign s1_vec.mid = r_lbq[0] & r_s1_ok.mid;
    assign s1_vec.bot = r_rda[AGE_BITS] & r_s1_ok.bot;

    always_ff @(posedge i_clk) begin
        if (lb_re) r_lbq <= r_lb[CW'(r_cc)];
        if (r_s1_ctl.valid && r_s1_col_real) r_lb[r_s1_lb_addr] <= {s1_vec.mid, s1_vec.bot};
    end

    lgge_window #(
        .AGE_BITS (AGE_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_ctl     (r_s1_ctl),
        .i_col     (s1_vec),
        .i_old_age (r_rdb[AGE_BITS-1:0]),
        .i_age_cap (r_age_cap),
        .o_alive   (win_alive),
        .o_age     (win_age)
    );

    assign o_out_valid = r_out_valid;
    assign o_alive_out = r_out_alive;
    assign o_age_out   = r_out_age;

endmodule
